FILE: src/sidiv_pkg.sv
package sidiv_pkg;

   // control that travels down the pipeline next to each operand pair
   typedef struct packed {
      logic valid;
      logic neg;
      logic sat;
      logic dbz;
   } sidiv_ctrl_type;

endpackage

FILE: src/sidiv_prep.sv
module sidiv_prep
   import sidiv_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [DATA_WIDTH-1:0] dividend,
   input  logic [DATA_WIDTH-1:0] divisor,
   output sidiv_ctrl_type        ctrl,
   output logic [DATA_WIDTH-1:0] num,
   output logic [DATA_WIDTH-1:0] den
);

   localparam logic [DATA_WIDTH-1:0] MinNeg = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   sidiv_ctrl_type        ctrl_ff, ctrl_in;
   logic [DATA_WIDTH-1:0] num_ff, num_in;
   logic [DATA_WIDTH-1:0] den_ff, den_in;

   always_comb begin
      ctrl_in.valid = accept;
      ctrl_in.neg   = dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
      ctrl_in.dbz   = (divisor == '0);
      ctrl_in.sat   = (dividend == MinNeg) && (divisor == '1);
      num_in = dividend[DATA_WIDTH-1] ? (~dividend + 1'b1) : dividend;
      den_in = divisor[DATA_WIDTH-1] ? (~divisor + 1'b1) : divisor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
   end

   assign ctrl = ctrl_ff;
   assign num  = num_ff;
   assign den  = den_ff;

endmodule

FILE: src/sidiv_step.sv
module sidiv_step
   import sidiv_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sidiv_ctrl_type        ctrl_i,
   input  logic [DATA_WIDTH-1:0] rem_i,
   input  logic [DATA_WIDTH-1:0] num_i,
   input  logic [DATA_WIDTH-1:0] den_i,
   output sidiv_ctrl_type        ctrl_o,
   output logic [DATA_WIDTH-1:0] rem_o,
   output logic [DATA_WIDTH-1:0] num_o,
   output logic [DATA_WIDTH-1:0] den_o
);

   sidiv_ctrl_type        ctrl_ff;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] num_ff, num_in;
   logic [DATA_WIDTH-1:0] den_ff;
   logic [DATA_WIDTH:0]   trial;
   logic                  fit;

   // num shifts left; its top bit feeds the remainder, the quotient bit fills the bottom
   always_comb begin
      trial  = {rem_i, num_i[DATA_WIDTH-1]} - {1'b0, den_i};
      fit    = ~trial[DATA_WIDTH];
      rem_in = fit ? trial[DATA_WIDTH-1:0] : {rem_i[DATA_WIDTH-2:0], num_i[DATA_WIDTH-1]};
      num_in = {num_i[DATA_WIDTH-2:0], fit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_i;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= den_i;
   end

   assign ctrl_o = ctrl_ff;
   assign rem_o  = rem_ff;
   assign num_o  = num_ff;
   assign den_o  = den_ff;

endmodule

FILE: src/sidiv_post.sv
module sidiv_post
   import sidiv_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sidiv_ctrl_type        ctrl,
   input  logic [DATA_WIDTH-1:0] quo,
   output logic                  strobe,
   output logic [DATA_WIDTH-1:0] quotient,
   output logic                  saturated,
   output logic                  divide_by_zero
);

   localparam logic [DATA_WIDTH-1:0] MaxPos = {1'b0, {(DATA_WIDTH-1){1'b1}}};

   logic                  strobe_ff;
   logic [DATA_WIDTH-1:0] quotient_ff, quotient_in;
   logic                  saturated_ff, dbz_ff;

   always_comb begin
      if (ctrl.dbz) begin
         quotient_in = '0;
      end else if (ctrl.sat) begin
         quotient_in = MaxPos;
      end else if (ctrl.neg) begin
         quotient_in = ~quo + 1'b1;
      end else begin
         quotient_in = quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      quotient_ff  <= quotient_in;
      saturated_ff <= ctrl.sat & ~ctrl.dbz;
      dbz_ff       <= ctrl.dbz;
   end

   assign strobe         = strobe_ff;
   assign quotient       = quotient_ff;
   assign saturated      = saturated_ff;
   assign divide_by_zero = dbz_ff;

endmodule

FILE: src/signed_integer_divider_core.sv
// an accepted pair passes through one operand stage, one restoring compare-subtract stage per
// quotient bit and one sign stage, whose register drives the result
// throughput: one transaction per cycle while busy is low; busy is high only while reset is held
// and in the cycle after it is released; reset clears every valid bit in the pipeline, so no
// result appears for work in flight; results are never held back: the receiver cannot stall
module signed_integer_divider_core
   import sidiv_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [DATA_WIDTH-1:0] req_dividend_value,
   input  logic [DATA_WIDTH-1:0] req_divisor_value,
   output logic                  rsp_strobe,
   output logic [DATA_WIDTH-1:0] rsp_quotient,
   output logic                  rsp_saturated,
   output logic                  rsp_divide_by_zero
);

   logic busy_ff;
   logic accept;

   sidiv_ctrl_type        ctrl_s [DATA_WIDTH+1];
   logic [DATA_WIDTH-1:0] rem_s  [DATA_WIDTH+1];
   logic [DATA_WIDTH-1:0] num_s  [DATA_WIDTH+1];
   logic [DATA_WIDTH-1:0] den_s  [DATA_WIDTH+1];

   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   assign busy   = busy_ff;
   assign accept = start & ~busy_ff;

   sidiv_prep #(.DATA_WIDTH(DATA_WIDTH)) u_prep (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .dividend (req_dividend_value),
      .divisor  (req_divisor_value),
      .ctrl     (ctrl_s[0]),
      .num      (num_s[0]),
      .den      (den_s[0])
   );

   assign rem_s[0] = '0;

   for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_step
      sidiv_step #(.DATA_WIDTH(DATA_WIDTH)) u_step (
         .clock  (clock),
         .reset  (reset),
         .ctrl_i (ctrl_s[g]),
         .rem_i  (rem_s[g]),
         .num_i  (num_s[g]),
         .den_i  (den_s[g]),
         .ctrl_o (ctrl_s[g+1]),
         .rem_o  (rem_s[g+1]),
         .num_o  (num_s[g+1]),
         .den_o  (den_s[g+1])
      );
   end

   sidiv_post #(.DATA_WIDTH(DATA_WIDTH)) u_post (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl_s[DATA_WIDTH]),
      .quo            (num_s[DATA_WIDTH]),
      .strobe         (rsp_strobe),
      .quotient       (rsp_quotient),
      .saturated      (rsp_saturated),
      .divide_by_zero (rsp_divide_by_zero)
   );

   // every accepted transaction produces a result strobe
   assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(DATA_WIDTH+2) rsp_strobe)
      else $error("accepted transaction did not produce a result");

   // no result without a matching accept
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, DATA_WIDTH+2))
      else $error("result strobe without an accepted transaction");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_divide_by_zero |-> rsp_quotient == '0 && !rsp_saturated)
      else $error("divide by zero result not cleared");

   // a nonzero ordinary quotient carries the xor of the operand signs
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_divide_by_zero && !rsp_saturated && rsp_quotient != '0
      |-> rsp_quotient[DATA_WIDTH-1] ==
          $past(req_dividend_value[DATA_WIDTH-1] ^ req_divisor_value[DATA_WIDTH-1],
                DATA_WIDTH+2))
      else $error("quotient sign mismatch");

endmodule
